>>> rtl/vn4_pkg.sv
// ----------------------------------------------------------------------------
// vn4_pkg: shared types and constants for the 4-d value noise core
// table geometry, fixed-point widths, hash and reduction schedule, codes
// ----------------------------------------------------------------------------
package vn4_pkg;

  localparam int TableSize  = 256;
  localparam int IdxBits    = $clog2(TableSize);
  localparam int FracBits   = 8;
  localparam int ValueBits  = 16;
  localparam int CoordBits  = 16;

  // hash chain schedule: 2 + 4 + 8 + 16 permutation reads
  localparam int PermReads   = 30;
  localparam int Level1Start = 2;
  localparam int Level2Start = 6;
  localparam int Level3Start = 14;
  localparam int HashRegs    = Level3Start;

  // reduction schedule: 8 lerps over x, 4 over y, 2 over z, 1 over t
  localparam int NumCorners = 16;
  localparam int NumLerps   = NumCorners - 1;
  localparam int LerpYStart = 8;
  localparam int LerpZStart = 12;
  localparam int LerpTStart = 14;

  typedef logic [IdxBits-1:0]          idx_t;
  typedef logic [FracBits-1:0]         frac_t;
  typedef logic signed [ValueBits-1:0] value_t;

  localparam value_t ValueMostNeg = {1'b1, {(ValueBits-1){1'b0}}};
  localparam value_t ValueFloor   = {1'b1, {(ValueBits-2){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    MODE_LOAD_NOISE = 2'd0,
    MODE_LOAD_PERM  = 2'd1,
    MODE_QUERY      = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  typedef struct packed {
    idx_t x;
    idx_t y;
    idx_t z;
    idx_t t;
  } lattice_t;

  typedef struct packed {
    frac_t x;
    frac_t y;
    frac_t z;
    frac_t t;
  } weights_t;

endpackage

>>> rtl/value_noise_4d_core.sv
// ----------------------------------------------------------------------------
// value_noise_4d_core: four-dimensional lattice value noise
// table loads and noise queries on one item stream, one result per query
//
//   channel  dir  payload
//   s_*      in   tuser: mode; tdata: address, noise value, perm value, x, y, z, t
//   m_*      out  tdata: noise_out
//
// a query runs from its accepting edge to the edge that raises m_tvalid: 30
// chained permutation reads, one per cycle through the single port of the
// permutation memory, with the 16 noise reads overlapping the last 16 of them,
// then 15 lerps on one shared multiplier; a new query is accepted only once
// the last result has been written to the output register
// the tables are undefined after reset until loaded
// s_tready is high whenever no query is in flight, also while m_tvalid waits;
// a result that finds the output register full is parked until it drains
// ----------------------------------------------------------------------------
module value_noise_4d_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] load_address, [23:8] load_noise_value, [31:24] load_perm_value,
  // [47:32] coord_x, [63:48] coord_y, [79:64] coord_z, [95:80] coord_t
  input  logic [95:0] s_tdata,
  // [1:0] mode
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [15:0] noise_out
  output logic [15:0] m_tdata
);

  localparam int AddrLsb  = 0;
  localparam int NoiseLsb = AddrLsb + vn4_pkg::IdxBits;
  localparam int PermLsb  = NoiseLsb + vn4_pkg::ValueBits;
  localparam int XLsb     = PermLsb + vn4_pkg::IdxBits;
  localparam int YLsb     = XLsb + vn4_pkg::CoordBits;
  localparam int ZLsb     = YLsb + vn4_pkg::CoordBits;
  localparam int TLsb     = ZLsb + vn4_pkg::CoordBits;

  vn4_pkg::state_t   state;
  vn4_pkg::state_t   state_next;
  vn4_pkg::mode_t    mode;
  vn4_pkg::lattice_t lattice;
  vn4_pkg::weights_t weights;
  vn4_pkg::idx_t     load_address;
  vn4_pkg::value_t   hold_data;
  vn4_pkg::value_t   interp_result;
  vn4_pkg::idx_t     corner_address;
  vn4_pkg::value_t   corner_value;
  logic              accept;
  logic              query_start;
  logic              noise_load;
  logic              perm_load;
  logic              out_free;
  logic              out_load_new;
  logic              out_load_hold;
  logic              hold_load;
  logic              corner_req;
  logic              corner_valid;
  logic              interp_done;

  assign mode         = vn4_pkg::mode_t'(s_tuser);
  assign accept       = s_tvalid && s_tready;
  assign load_address = s_tdata[AddrLsb +: vn4_pkg::IdxBits];
  assign noise_load   = accept && (mode == vn4_pkg::MODE_LOAD_NOISE);
  assign perm_load    = accept && (mode == vn4_pkg::MODE_LOAD_PERM);
  assign out_free     = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      vn4_pkg::ST_IDLE: begin
        if (accept && mode == vn4_pkg::MODE_QUERY) begin
          state_next = vn4_pkg::ST_RUN;
        end
      end
      vn4_pkg::ST_RUN: begin
        if (interp_done) begin
          state_next = out_free ? vn4_pkg::ST_IDLE : vn4_pkg::ST_HOLD;
        end
      end
      vn4_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = vn4_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vn4_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    query_start   = 1'b0;
    out_load_new  = 1'b0;
    out_load_hold = 1'b0;
    hold_load     = 1'b0;
    case (state)
      vn4_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        query_start = s_tvalid && (mode == vn4_pkg::MODE_QUERY);
      end
      vn4_pkg::ST_RUN: begin
        out_load_new = interp_done && out_free;
        hold_load    = interp_done && !out_free;
      end
      vn4_pkg::ST_HOLD: begin
        out_load_hold = out_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= vn4_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load_new || out_load_hold) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // integer part picks the lattice cell, low bits are the lerp weight
  always_ff @(posedge clk) begin
    if (query_start) begin
      lattice.x <= s_tdata[XLsb + vn4_pkg::FracBits +: vn4_pkg::IdxBits];
      lattice.y <= s_tdata[YLsb + vn4_pkg::FracBits +: vn4_pkg::IdxBits];
      lattice.z <= s_tdata[ZLsb + vn4_pkg::FracBits +: vn4_pkg::IdxBits];
      lattice.t <= s_tdata[TLsb + vn4_pkg::FracBits +: vn4_pkg::IdxBits];
      weights.x <= s_tdata[XLsb +: vn4_pkg::FracBits];
      weights.y <= s_tdata[YLsb +: vn4_pkg::FracBits];
      weights.z <= s_tdata[ZLsb +: vn4_pkg::FracBits];
      weights.t <= s_tdata[TLsb +: vn4_pkg::FracBits];
    end
    if (hold_load) begin
      hold_data <= interp_result;
    end
    if (out_load_new) begin
      m_tdata <= interp_result;
    end else if (out_load_hold) begin
      m_tdata <= hold_data;
    end
  end

  vn4_hash u_hash (
    .clk            (clk),
    .rst            (rst),
    .load_en        (perm_load),
    .load_address   (load_address),
    .load_value     (s_tdata[PermLsb +: vn4_pkg::IdxBits]),
    .start          (query_start),
    .lattice        (lattice),
    .corner_valid   (corner_req),
    .corner_address (corner_address)
  );

  vn4_noise_ram u_noise_ram (
    .clk          (clk),
    .rst          (rst),
    .load_en      (noise_load),
    .load_address (load_address),
    .load_value   (s_tdata[NoiseLsb +: vn4_pkg::ValueBits]),
    .rd_en        (corner_req),
    .rd_address   (corner_address),
    .value_valid  (corner_valid),
    .value        (corner_value)
  );

  vn4_interp u_interp (
    .clk          (clk),
    .rst          (rst),
    .start        (query_start),
    .weights      (weights),
    .corner_valid (corner_valid),
    .corner_value (corner_value),
    .done         (interp_done),
    .result       (interp_result)
  );

endmodule

>>> rtl/vn4_hash.sv
// ----------------------------------------------------------------------------
// vn4_hash: permutation memory and chained corner hash
// one permutation read per cycle, levels t, z, y, x; the x level yields
// the 16 noise addresses in corner order (x fastest, then y, z, t)
// ----------------------------------------------------------------------------
module vn4_hash (
  input  logic              clk,
  input  logic              rst,
  input  logic              load_en,
  input  vn4_pkg::idx_t     load_address,
  input  vn4_pkg::idx_t     load_value,
  input  logic              start,
  input  vn4_pkg::lattice_t lattice,
  output logic              corner_valid,
  output vn4_pkg::idx_t     corner_address
);

  localparam int StepBits = $clog2(vn4_pkg::PermReads);
  localparam int HashBits = $clog2(vn4_pkg::HashRegs);

  vn4_pkg::idx_t         mem [vn4_pkg::TableSize];
  vn4_pkg::idx_t         hash_reg [vn4_pkg::HashRegs];
  vn4_pkg::idx_t         rd_data;
  vn4_pkg::idx_t         base;
  vn4_pkg::idx_t         parent;
  vn4_pkg::idx_t         rd_address;
  vn4_pkg::idx_t         mem_address;
  logic [StepBits-1:0]   step;
  logic [StepBits-1:0]   step_d;
  logic [StepBits-1:0]   parent_step;
  logic                  busy;
  logic                  rd_valid;

  // step k reads parent hash (k/2 - 1); hashes are stored at their own step
  assign parent_step = (step >> 1) - StepBits'(1);

  always_comb begin
    if (step < StepBits'(vn4_pkg::Level1Start)) begin
      base   = lattice.t;
      parent = '0;
    end else if (step < StepBits'(vn4_pkg::Level2Start)) begin
      base   = lattice.z;
      parent = hash_reg[parent_step[HashBits-1:0]];
    end else if (step < StepBits'(vn4_pkg::Level3Start)) begin
      base   = lattice.y;
      parent = hash_reg[parent_step[HashBits-1:0]];
    end else begin
      base   = lattice.x;
      parent = hash_reg[parent_step[HashBits-1:0]];
    end
  end

  // low step bit selects the +1 corner on this axis; sums wrap on the table
  assign rd_address  = base + parent + vn4_pkg::idx_t'(step[0]);
  assign mem_address = load_en ? load_address : rd_address;

  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[mem_address] <= load_value;
    end
    rd_data <= mem[mem_address];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      step     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= busy;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == StepBits'(vn4_pkg::PermReads - 1)) begin
          busy <= 1'b0;
        end
        step <= step + StepBits'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    step_d <= step;
    if (rd_valid && step_d < StepBits'(vn4_pkg::Level3Start)) begin
      hash_reg[step_d[HashBits-1:0]] <= rd_data;
    end
  end

  assign corner_valid   = rd_valid && (step_d >= StepBits'(vn4_pkg::Level3Start));
  assign corner_address = rd_data;

endmodule

>>> rtl/vn4_noise_ram.sv
// ----------------------------------------------------------------------------
// vn4_noise_ram: noise value memory
// single port, loads saturate the most negative code, reads return next cycle
// ----------------------------------------------------------------------------
module vn4_noise_ram (
  input  logic            clk,
  input  logic            rst,
  input  logic            load_en,
  input  vn4_pkg::idx_t   load_address,
  input  vn4_pkg::value_t load_value,
  input  logic            rd_en,
  input  vn4_pkg::idx_t   rd_address,
  output logic            value_valid,
  output vn4_pkg::value_t value
);

  vn4_pkg::value_t mem [vn4_pkg::TableSize];
  vn4_pkg::value_t wr_value;
  vn4_pkg::idx_t   mem_address;

  // keep the range symmetric so every lerp stays in range
  assign wr_value    = (load_value == vn4_pkg::ValueMostNeg) ? vn4_pkg::ValueFloor
                                                             : load_value;
  assign mem_address = load_en ? load_address : rd_address;

  always_ff @(posedge clk) begin
    if (load_en) begin
      mem[mem_address] <= wr_value;
    end
    value <= mem[mem_address];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_valid <= 1'b0;
    end else begin
      value_valid <= rd_en && !load_en;
    end
  end

endmodule

>>> rtl/vn4_interp.sv
// ----------------------------------------------------------------------------
// vn4_interp: corner queue and shared lerp unit
// corners fill a shift queue; each lerp pops two, and all but the last append
// their result, so the x, y, z and t levels fall out in breadth-first order
// ----------------------------------------------------------------------------
module vn4_interp (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  vn4_pkg::weights_t weights,
  input  logic              corner_valid,
  input  vn4_pkg::value_t   corner_value,
  output logic              done,
  output vn4_pkg::value_t   result
);

  localparam int CountBits = $clog2(vn4_pkg::NumCorners + 1);
  localparam int LerpBits  = $clog2(vn4_pkg::NumLerps + 1);
  localparam int DiffBits  = vn4_pkg::ValueBits + 1;
  localparam int ProdBits  = DiffBits + vn4_pkg::FracBits + 1;
  localparam int SumBits   = vn4_pkg::ValueBits + vn4_pkg::FracBits + 2;
  localparam logic signed [SumBits-1:0] HalfStep = SumBits'(1) << (vn4_pkg::FracBits - 1);

  vn4_pkg::value_t             queue [vn4_pkg::NumCorners];
  logic [CountBits-1:0]        count;
  logic [CountBits-1:0]        corners;
  logic [CountBits-1:0]        push_pos;
  logic [LerpBits-1:0]         issued;
  logic                        pop;
  logic                        push_en;
  vn4_pkg::value_t             push_data;
  vn4_pkg::frac_t              weight;
  logic signed [DiffBits-1:0]  diff;
  logic signed [ProdBits-1:0]  prod;
  logic signed [SumBits-1:0]   sum;
  vn4_pkg::value_t             lerp_value;
  logic                        s1_valid;
  logic                        s1_last;
  vn4_pkg::value_t             s1_base;
  logic signed [ProdBits-1:0]  s1_prod;

  assign pop = (corners == CountBits'(vn4_pkg::NumCorners))
            && (issued != LerpBits'(vn4_pkg::NumLerps))
            && (count >= CountBits'(2));

  always_comb begin
    if (issued < LerpBits'(vn4_pkg::LerpYStart)) begin
      weight = weights.x;
    end else if (issued < LerpBits'(vn4_pkg::LerpZStart)) begin
      weight = weights.y;
    end else if (issued < LerpBits'(vn4_pkg::LerpTStart)) begin
      weight = weights.z;
    end else begin
      weight = weights.t;
    end
  end

  // a*(1-w) + b*w == a*one + (b-a)*w
  assign diff = {queue[1][vn4_pkg::ValueBits-1], queue[1]}
              - {queue[0][vn4_pkg::ValueBits-1], queue[0]};
  assign prod = diff * $signed({1'b0, weight});

  assign sum = (SumBits'(s1_base) <<< vn4_pkg::FracBits) + SumBits'(s1_prod) + HalfStep;
  assign lerp_value = vn4_pkg::value_t'(sum >>> vn4_pkg::FracBits);

  assign push_en   = corner_valid || (s1_valid && !s1_last);
  assign push_data = corner_valid ? corner_value : lerp_value;
  assign push_pos  = pop ? count - CountBits'(2) : count;

  always_ff @(posedge clk) begin
    for (int i = 0; i < vn4_pkg::NumCorners; i++) begin
      if (push_en && push_pos == CountBits'(i)) begin
        queue[i] <= push_data;
      end else if (pop && i < vn4_pkg::NumCorners - 2) begin
        queue[i] <= queue[(i + 2) % vn4_pkg::NumCorners];
      end
    end
    s1_base <= queue[0];
    s1_prod <= prod;
    s1_last <= (issued == LerpBits'(vn4_pkg::NumLerps - 1));
    result  <= lerp_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      corners  <= '0;
      issued   <= '0;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= pop;
      done     <= s1_valid && s1_last;
      if (start) begin
        count   <= '0;
        corners <= '0;
        issued  <= '0;
      end else begin
        count <= push_pos + CountBits'(push_en);
        if (corner_valid) begin
          corners <= corners + CountBits'(1);
        end
        if (pop) begin
          issued <= issued + LerpBits'(1);
        end
      end
    end
  end

endmodule
